// ===== hw/rtl/rlts_pkg.sv =====
// Shared types and constants of the road line tile sequencer.
package rlts_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CLIP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT   = 3'd4;

  localparam logic [9:0] RIGHT_CLIP_RST = 10'd319;
  localparam logic [2:0] PRIORITY_B_RST = 3'd7;

  localparam int unsigned POS_W   = 17;  // signed, 1/8 pixel units
  localparam int unsigned STEP_W  = 11;
  localparam int unsigned SCALE_W = 18;
  localparam int unsigned CNT_W   = 5;

  localparam logic [STEP_W-1:0]  PLAIN_STEP     = 11'd512;
  localparam logic [SCALE_W-1:0] PLAIN_SCALE    = 18'h10000;
  localparam logic [SCALE_W-1:0] ZOOM_SCALE_PAD = 18'd1024;
  localparam logic [CNT_W-1:0]   PLAIN_LAST_CNT = 5'd16;
  localparam logic [CNT_W-1:0]   ZOOM_LAST_CNT  = 5'd15;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0]         line;
    logic [15:0]        row;
    logic [3:0]         idx0;
    logic [15:0]        color;
    logic [POS_W-1:0]   pos0;
    logic [STEP_W-1:0]  step;
    logic [SCALE_W-1:0] scale;
    logic [CNT_W-1:0]   last_cnt;
  } job_t;

  typedef struct packed {
    logic [9:0] right_clip;
    logic       transparent;
  } draw_cfg_t;

endpackage

// ===== hw/rtl/rlts_line_if.sv =====
// Input channel: one scanline's road words.
interface rlts_line_if;
  logic        valid;
  logic        ready;
  logic [7:0]  line;
  logic [15:0] word_zero;
  logic [15:0] word_one;
  logic [15:0] word_two;
  logic [15:0] word_three;

  modport source (output valid, line, word_zero, word_one, word_two, word_three,
                  input ready);
  modport sink (input valid, line, word_zero, word_one, word_two, word_three,
                output ready);
endinterface

// ===== hw/rtl/rlts_tile_if.sv =====
// Output channel: one tile draw command.
interface rlts_tile_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_line;
  logic [19:0] tile_code;
  logic [15:0] color;
  logic [11:0] x_pixel;
  logic [17:0] x_scale;
  logic        pen_transparent;
  logic        last;

  modport source (output valid, out_line, tile_code, color, x_pixel, x_scale,
                  pen_transparent, last, input ready);
  modport sink (input valid, out_line, tile_code, color, x_pixel, x_scale,
                pen_transparent, last, output ready);
endinterface

// ===== hw/rtl/rlts_front.sv =====
// Front end: configuration registers, priority check and line job setup.
module rlts_front import rlts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rlts_line_if.sink             line_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output job_t                  job_o,
  output draw_cfg_t             draw_cfg_o
);

  logic       zoom_q;
  logic [2:0] prio_a_q;
  logic [2:0] prio_b_q;
  logic [9:0] clip_q;
  logic       transp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q   <= 1'b0;
      prio_a_q <= 3'd0;
      prio_b_q <= PRIORITY_B_RST;
      clip_q   <= RIGHT_CLIP_RST;
      transp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ZOOM_MODE:   zoom_q   <= cfg_data_i[0];
        CFG_PRIORITY_A:  prio_a_q <= cfg_data_i[2:0];
        CFG_PRIORITY_B:  prio_b_q <= cfg_data_i[2:0];
        CFG_RIGHT_CLIP:  clip_q   <= cfg_data_i;
        CFG_TRANSPARENT: transp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [2:0]        lo, hi, prio;
  logic              in_window;
  logic [STEP_W-1:0] zp1;
  logic [POS_W-1:0]  zoom_px;

  always_comb begin
    lo   = (prio_a_q < prio_b_q) ? prio_a_q : prio_b_q;
    hi   = (prio_a_q < prio_b_q) ? prio_b_q : prio_a_q;
    prio = zoom_q ? line_i.word_zero[14:12] : line_i.word_two[10:8];
    in_window = (prio >= lo) && (prio <= hi);

    zp1     = {1'b0, line_i.word_one[9:0]} + STEP_W'(1);
    zoom_px = POS_W'(1024) - {{(POS_W-11){1'b0}}, line_i.word_zero[10:0]}
              - {{(POS_W-STEP_W){1'b0}}, zp1};

    job_o.line = line_i.line;
    if (zoom_q) begin
      job_o.row      = line_i.word_three;
      job_o.idx0     = 4'd0;
      job_o.color    = {8'h00, line_i.word_two[15:8]};
      job_o.pos0     = {zoom_px[POS_W-4:0], 3'b000};
      job_o.step     = zp1;
      job_o.scale    = {zp1, 7'b0} + ZOOM_SCALE_PAD;
      job_o.last_cnt = ZOOM_LAST_CNT;
    end else begin
      job_o.row      = line_i.word_zero;
      job_o.idx0     = line_i.word_one[9:6];
      job_o.color    = line_i.word_two;
      job_o.pos0     = POS_W'(0) - {{(POS_W-9){1'b0}}, line_i.word_one[5:0], 3'b000};
      job_o.step     = PLAIN_STEP;
      job_o.scale    = PLAIN_SCALE;
      job_o.last_cnt = PLAIN_LAST_CNT;
    end
  end

  assign line_i.ready = !q_full_i;
  assign push_o       = line_i.valid && !q_full_i && in_window;
  assign draw_cfg_o   = '{right_clip: clip_q, transparent: transp_q};

endmodule

// ===== hw/rtl/rlts_queue.sv =====
// Two-entry job queue between front and back end.
module rlts_queue import rlts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (QPTR_W+1)'(push_i && !full_o) - (QPTR_W+1)'(pop_i && valid_o);
    end
  end

endmodule

// ===== hw/rtl/rlts_back.sv =====
// Back end: walks one line job and issues a tile command per cycle while the tile output is not stalled.
module rlts_back import rlts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  input  draw_cfg_t draw_cfg_i,
  rlts_tile_if.source tile_o
);

  logic                    busy_q;
  logic signed [POS_W-1:0] pos_q;
  logic [3:0]              idx_q;
  logic [CNT_W-1:0]        cnt_q;

  logic                    valid_q;
  logic [7:0]              line_q;
  logic [19:0]             code_q;
  logic [15:0]             color_q;
  logic [11:0]             x_q;
  logic [SCALE_W-1:0]      scale_q;
  logic                    transp_q;
  logic                    last_q;

  logic signed [POS_W-1:0] cur_pos, nxt_pos, clip8;
  logic [3:0]              cur_idx;
  logic [CNT_W-1:0]        cur_cnt;
  logic                    slot_free, go, beyond, last, emit;

  always_comb begin
    cur_pos   = busy_q ? pos_q : $signed(head_i.pos0);
    cur_idx   = busy_q ? idx_q : head_i.idx0;
    cur_cnt   = busy_q ? cnt_q : '0;
    clip8     = $signed({{(POS_W-13){1'b0}}, draw_cfg_i.right_clip, 3'b000});
    nxt_pos   = cur_pos + $signed({{(POS_W-STEP_W){1'b0}}, head_i.step});
    slot_free = !valid_q || tile_o.ready;
    go        = q_valid_i && slot_free;
    beyond    = cur_pos > clip8;
    last      = (nxt_pos > clip8) || (cur_cnt == head_i.last_cnt);
    emit      = go && !beyond;
    pop_o     = go && (beyond || last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        busy_q <= 1'b1;
      end
      if (emit) begin
        valid_q <= 1'b1;
      end else if (tile_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pos_q    <= nxt_pos;
      idx_q    <= cur_idx + 4'd1;
      cnt_q    <= cur_cnt + CNT_W'(1);
      line_q   <= head_i.line;
      code_q   <= {head_i.row, cur_idx};
      color_q  <= head_i.color;
      x_q      <= cur_pos[14:3];
      scale_q  <= head_i.scale;
      transp_q <= draw_cfg_i.transparent;
      last_q   <= last;
    end
  end

  assign tile_o.valid           = valid_q;
  assign tile_o.out_line        = line_q;
  assign tile_o.tile_code       = code_q;
  assign tile_o.color           = color_q;
  assign tile_o.x_pixel         = x_q;
  assign tile_o.x_scale         = scale_q;
  assign tile_o.pen_transparent = transp_q;
  assign tile_o.last            = last_q;

endmodule

// ===== hw/rtl/road_line_tile_sequencer.sv =====
// Road line tile sequencer top level.
// A scanline is taken when the two-entry line queue has room;
// lines outside the priority window are dropped there. The back end issues
// one tile command per cycle while the tile output is not stalled, so a line
// with n tiles (1 to 17 plain, 0 to 16 zoom) holds it until all n are issued;
// a zoomed line that starts past the clip issues none. Throughput per line is
// set by the single tile issue path of the back end.
module road_line_tile_sequencer import rlts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rlts_line_if.sink             line_i,
  rlts_tile_if.source           tile_o
);

  logic      q_full, push, q_valid, pop;
  job_t      job, head;
  draw_cfg_t draw_cfg;

  rlts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .line_i     (line_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job),
    .draw_cfg_o (draw_cfg)
  );

  rlts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  rlts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .head_i     (head),
    .pop_o      (pop),
    .draw_cfg_i (draw_cfg),
    .tile_o     (tile_o)
  );

endmodule
